FILE: rtl/tlq_pkg.sv
`default_nettype none
package tlq_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  // next pointers carry one more bit for the end-of-chain marker (value SLOTS)
  localparam int NEXT_W = SLOT_W + 1;
  localparam int PAY_W  = 80;

  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  localparam logic [1:0] NORMAL_PASS_LIMIT = 2'd2;
  localparam logic [2:0] LOW_PASS_LIMIT    = 3'd4;

  localparam logic MODE_ENQ = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [1:0]  level;
    logic [31:0] job_proc;
    logic [31:0] job_context;
    logic [15:0] extra_flags;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        pool_full;
    logic        queues_empty;
    logic [1:0]  out_level;
    logic [31:0] out_proc;
    logic [31:0] out_context;
    logic [15:0] out_flags;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_FULL,
    OP_EMPTY,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic start;
    logic finish;
  } ctl_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/tlq_ram.sv
`default_nettype none
module tlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tlq_ctrl.sv
`default_nettype none
module tlq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tlq_pkg::ctl_cmd_t     cmd
);
  import tlq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        // only take a transaction once the result slot will be free
        in_ready  = rst_n && (!out_valid_r || out_ready);
        cmd.start = in_valid && in_ready;
        if (cmd.start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/tlq_dp.sv
`default_nettype none
module tlq_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tlq_pkg::ctl_cmd_t cmd,
  input  wire tlq_pkg::in_item_t in_data,
  output tlq_pkg::out_item_t     out_data
);
  import tlq_pkg::*;

  // free list, queue pointers and pass counters
  logic              fv_r, fv_nxt;
  logic [SLOT_W-1:0] fh_r, fh_nxt;
  logic [2:0]        hv_r, hv_nxt;
  logic [SLOT_W-1:0] qhead_r [3];
  logic [SLOT_W-1:0] qhead_nxt [3];
  logic [SLOT_W-1:0] qtail_r [3];
  logic [SLOT_W-1:0] qtail_nxt [3];
  logic [1:0]        ns_r, ns_nxt;
  logic [2:0]        ls_r, ls_nxt;
  logic [SLOTS-1:0]  nv_r, nv_nxt;   // slot_next entry written since reset

  // per-transaction registers
  op_t               op_r;
  logic [1:0]        lvl_r;
  logic [SLOT_W-1:0] s_r;
  logic              fresh_r;
  in_item_t          in_r;
  out_item_t         out_r;

  // level choice
  logic       hi, no, lo;
  logic [1:0] ns_inc, ch_ns;
  logic [2:0] ls_inc, ch_ls;
  logic [1:0] lv_sel;
  op_t        op_sel;

  logic [1:0]        idx, idx_c;
  logic [SLOT_W-1:0] qh_sel, qt_sel, s_sel;

  logic              nx_we;
  logic [SLOT_W-1:0] nx_waddr;
  logic [NEXT_W-1:0] nx_wdata, nx_q, nxt;
  logic              pay_we;
  logic [PAY_W-1:0]  pay_q;

  // result word for the transaction in flight
  function automatic out_item_t build_out(op_t op, logic [1:0] lv, logic [PAY_W-1:0] p);
    out_item_t o;
    o = '0;
    unique case (op)
      OP_ENQ:   o.accepted = 1'b1;
      OP_FULL:  o.pool_full = 1'b1;
      OP_EMPTY: o.queues_empty = 1'b1;
      OP_DEQ: begin
        o.accepted    = 1'b1;
        o.out_level   = lv;
        o.out_proc    = p[79:48];
        o.out_context = p[47:16];
        o.out_flags   = p[15:0];
      end
      OP_NOP:   o = '0;
      default:  o = '0;
    endcase
    return o;
  endfunction

  assign hi     = hv_r[LVL_HIGH];
  assign no     = hv_r[LVL_NORMAL];
  assign lo     = hv_r[LVL_LOW];
  assign ns_inc = ns_r + 2'd1;
  assign ls_inc = ls_r + 3'd1;

  // short-circuit evaluation: a counter moves only when its test is reached
  always_comb begin
    ch_ns  = ns_r;
    ch_ls  = ls_r;
    lv_sel = LVL_LOW;
    if (hi && (!no || ns_inc < NORMAL_PASS_LIMIT)) begin
      if (no) begin
        ch_ns = ns_inc;
      end
      if (!lo) begin
        lv_sel = LVL_HIGH;
      end else begin
        ch_ls  = ls_inc;
        lv_sel = (ls_inc < LOW_PASS_LIMIT) ? LVL_HIGH : LVL_LOW;
      end
    end else begin
      if (hi) begin
        ch_ns = ns_inc;
      end
      if (no) begin
        if (hi || !lo) begin
          lv_sel = LVL_NORMAL;
        end else begin
          ch_ls  = ls_inc;
          lv_sel = (ls_inc < LOW_PASS_LIMIT) ? LVL_NORMAL : LVL_LOW;
        end
      end
    end
    if (lv_sel == LVL_NORMAL) begin
      ch_ns = '0;
    end else if (lv_sel == LVL_LOW) begin
      ch_ls = '0;
    end
  end

  always_comb begin
    if (in_data.mode == MODE_ENQ) begin
      if (in_data.level > LVL_LOW) begin
        op_sel = OP_NOP;
      end else if (!fv_r) begin
        op_sel = OP_FULL;
      end else begin
        op_sel = OP_ENQ;
      end
    end else begin
      op_sel = (|hv_r) ? OP_DEQ : OP_EMPTY;
    end
  end

  // one level index per cycle selects the queue pointers
  assign idx    = cmd.start ? ((in_data.mode == MODE_ENQ) ? in_data.level : lv_sel) : lvl_r;
  assign idx_c  = (idx > LVL_LOW) ? LVL_HIGH : idx;
  assign qh_sel = qhead_r[idx_c];
  assign qt_sel = qtail_r[idx_c];
  assign s_sel  = (in_data.mode == MODE_ENQ) ? fh_r : qh_sel;

  // never-written next entries are taken as the reset chain value, slot + 1
  assign nxt = fresh_r ? ({1'b0, s_r} + NEXT_W'(1)) : nx_q;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= op_sel;
      lvl_r   <= idx_c;
      s_r     <= s_sel;
      fresh_r <= !nv_r[s_sel];
      in_r    <= in_data;
    end
    if (cmd.finish) begin
      out_r <= build_out(op_r, lvl_r, pay_q);
    end
  end

  always_comb begin
    fv_nxt    = fv_r;
    fh_nxt    = fh_r;
    hv_nxt    = hv_r;
    qhead_nxt = qhead_r;
    qtail_nxt = qtail_r;
    ns_nxt    = ns_r;
    ls_nxt    = ls_r;
    nv_nxt    = nv_r;
    nx_we     = 1'b0;
    nx_waddr  = s_r;
    nx_wdata  = NEXT_W'(SLOTS);
    pay_we    = 1'b0;
    if (cmd.start && op_sel == OP_DEQ) begin
      ns_nxt = ch_ns;
      ls_nxt = ch_ls;
    end
    if (cmd.finish) begin
      unique case (op_r)
        OP_ENQ: begin
          pay_we = 1'b1;
          if (nxt >= NEXT_W'(SLOTS)) begin
            fv_nxt = 1'b0;
          end else begin
            fh_nxt = nxt[SLOT_W-1:0];
          end
          if (hv_r[lvl_r]) begin
            nx_we    = 1'b1;
            nx_waddr = qt_sel;
            nx_wdata = {1'b0, s_r};
          end else begin
            hv_nxt[lvl_r]    = 1'b1;
            qhead_nxt[lvl_r] = s_r;
          end
          qtail_nxt[lvl_r] = s_r;
        end
        OP_DEQ: begin
          if (s_r == qt_sel) begin
            hv_nxt[lvl_r] = 1'b0;
          end else begin
            qhead_nxt[lvl_r] = nxt[SLOT_W-1:0];
          end
          // freed slot goes straight onto the free list
          nx_we    = 1'b1;
          nx_waddr = s_r;
          nx_wdata = fv_r ? {1'b0, fh_r} : NEXT_W'(SLOTS);
          fh_nxt   = s_r;
          fv_nxt   = 1'b1;
        end
        OP_FULL, OP_EMPTY, OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
    if (nx_we) begin
      nv_nxt[nx_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r    <= 1'b1;
      fh_r    <= '0;
      hv_r    <= '0;
      qtail_r <= '{default: '0};
      ns_r    <= '0;
      ls_r    <= '0;
      nv_r    <= '0;
    end else begin
      fv_r    <= fv_nxt;
      fh_r    <= fh_nxt;
      hv_r    <= hv_nxt;
      qtail_r <= qtail_nxt;
      ns_r    <= ns_nxt;
      ls_r    <= ls_nxt;
      nv_r    <= nv_nxt;
    end
  end

  // head pointers are don't-care while their valid bit is clear
  always_ff @(posedge clk) begin
    qhead_r <= qhead_nxt;
  end

  tlq_ram #(
    .WIDTH (NEXT_W),
    .DEPTH (SLOTS)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (cmd.start),
    .raddr (s_sel),
    .rdata (nx_q)
  );

  tlq_ram #(
    .WIDTH (PAY_W),
    .DEPTH (SLOTS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (s_r),
    .wdata ({in_r.job_proc, in_r.job_context, in_r.extra_flags}),
    .re    (cmd.start),
    .raddr (s_sel),
    .rdata (pay_q)
  );

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: rtl/three_level_weighted_job_queue_top.sv
`default_nettype none
// Result: an accepted transaction goes from IDLE to EXEC, and its result
//   is registered as EXEC ends. Input is taken only in IDLE; the slot RAM
//   read at accept must return before the queue head and free list can move.
// Reset: synchronous, active low; queues empty, all slots free, counters zero.
//   No clearing pass: per-slot written flags stand in for the free chain.
module three_level_weighted_job_queue_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tlq_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tlq_pkg::out_item_t     out_data
);
  import tlq_pkg::*;

  ctl_cmd_t cmd;

  tlq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tlq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/tlq_checker.sv
`default_nettype none
module tlq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire tlq_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire tlq_pkg::out_item_t out_data
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.accepted, out_data.pool_full,
                              out_data.queues_empty}) <= 1)
    else $error("result flags overlap");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.queues_empty || out_data.pool_full) |->
      out_data.out_proc == 32'd0 && out_data.out_context == 32'd0 &&
      out_data.out_flags == 16'd0 && out_data.out_level == 2'd0)
    else $error("rejected transaction carries a job");

endmodule

bind three_level_weighted_job_queue_top tlq_checker u_chk (.*);
`default_nettype wire
